// ----- src/shc_pkg.sv -----
// Shared types and constants for the scoreboard issue hazard check.
// Holds the beat structs, opcode and stall reason codes, and the latency table.
// No dependencies.
package shc_pkg;

	localparam int NUM_REGS    = 64;
	localparam int REG_W       = $clog2(NUM_REGS);
	localparam int BUSY_W      = 3;
	localparam int SLOT_W      = 7;
	localparam int FLOAT_STALL = 5;

	localparam logic [2:0] OP_NOP    = 3'd0;
	localparam logic [2:0] OP_LOAD   = 3'd1;
	localparam logic [2:0] OP_STORE  = 3'd2;
	localparam logic [2:0] OP_ARITH  = 3'd3;
	localparam logic [2:0] OP_BRANCH = 3'd4;
	localparam logic [2:0] OP_JUMP   = 3'd5;
	localparam logic [2:0] OP_FLOAT  = 3'd6;
	localparam logic [2:0] OP_OTHER  = 3'd7;

	typedef enum logic [2:0] {
		RSN_NONE      = 3'd0,
		RSN_RAW       = 3'd1,
		RSN_FLOAT     = 3'd2,
		RSN_WRITEPORT = 3'd3,
		RSN_WAW       = 3'd4,
		RSN_ROB_FULL  = 3'd5
	} reason_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [5:0] src_a;
		logic [5:0] src_b;
		logic [5:0] dest;
		logic       rob_full;
	} instr_t;

	typedef struct packed {
		logic    issued;
		reason_t stall_reason;
		logic [2:0] done_after;
	} result_t;

	function automatic logic [BUSY_W-1:0] op_latency(input logic [2:0] op);
		logic [BUSY_W-1:0] lat;
		unique case (op)
			OP_NOP:    lat = 3'd1;
			OP_LOAD:   lat = 3'd2;
			OP_STORE:  lat = 3'd2;
			OP_ARITH:  lat = 3'd1;
			OP_BRANCH: lat = 3'd1;
			OP_JUMP:   lat = 3'd1;
			OP_FLOAT:  lat = 3'd5;
			OP_OTHER:  lat = 3'd1;
			default:   lat = 3'd1;
		endcase
		return lat;
	endfunction

	// Map a register field onto the table; out-of-range registers become register 0.
	function automatic logic [REG_W-1:0] reg_idx(input logic [5:0] r);
		logic [31:0] wide;
		wide = 32'(r);
		if (wide < 32'(NUM_REGS)) begin
			return wide[REG_W-1:0];
		end
		return '0;
	endfunction

endpackage

// ----- src/scoreboard_issue_hazard_check_unit.sv -----
// Top level of the scoreboard issue hazard check.
// Holds the input register, the scoreboard state, the checks and the result register.
// Depends on shc_pkg.

// One beat on instr is one decode cycle of the processor; the unit answers each with
// exactly one beat on res giving issue or the stall reason and the completion delay.
// A beat is taken into an input register, checked against the scoreboard in
// combinational logic, and moved into the result register; the scoreboard
// countdowns and the write-port mask advance when that happens. A new beat is taken
// every cycle, so throughput is one beat per clock as long as res is not stalled;
// from instr to res a beat passes the input register and then the result register.
module scoreboard_issue_hazard_check_unit
	import shc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    instr_valid,
	output logic    instr_stall,
	input  instr_t  instr,
	output logic    res_valid,
	input  logic    res_stall,
	output result_t res
);

	logic    valid_s1;
	instr_t  instr_s1;
	logic    advance;

	logic [BUSY_W-1:0] busy_q   [NUM_REGS];
	logic [BUSY_W-1:0] busy_dec [NUM_REGS];
	logic [SLOT_W-1:0] slot_q;
	logic [BUSY_W-1:0] float_q;

	logic [REG_W-1:0]  ra, rb, rd;
	logic [BUSY_W-1:0] lat;
	logic              is_store, is_float, writes;
	logic [SLOT_W-1:0] slot, slot_dec;
	logic [BUSY_W-1:0] float_dec;
	logic              raw;
	reason_t           reason;
	logic              issue;

	assign advance     = valid_s1 && (!res_valid || !res_stall);
	assign instr_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!instr_stall) begin
			valid_s1 <= instr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (instr_valid && !instr_stall) begin
			instr_s1 <= instr;
		end
	end

	// Time steps once per checked beat: drop all countdowns, shift the port mask.
	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			busy_dec[i] = (busy_q[i] != '0) ? busy_q[i] - 1'b1 : '0;
		end
	end

	assign slot_dec  = slot_q >> 1;
	assign float_dec = (float_q != '0) ? float_q - 1'b1 : '0;

	assign ra       = reg_idx(instr_s1.src_a);
	assign rb       = reg_idx(instr_s1.src_b);
	assign rd       = reg_idx(instr_s1.dest);
	assign lat      = op_latency(instr_s1.opcode);
	assign is_store = (instr_s1.opcode == OP_STORE);
	assign is_float = (instr_s1.opcode == OP_FLOAT);
	assign writes   = (rd != '0) && !is_store;
	assign slot     = SLOT_W'(1) << (lat + 1'b1);

	assign raw = ((ra != '0) && (busy_dec[ra] != '0))
		|| ((rb != '0) && (busy_dec[rb] != '0))
		|| (is_store && (rd != '0) && (busy_dec[rd] != '0));

	always_comb begin
		priority if (raw) begin
			reason = RSN_RAW;
		end else if (is_float && (float_dec != '0)) begin
			reason = RSN_FLOAT;
		end else if (writes && ((slot_dec & slot) != '0)) begin
			reason = RSN_WRITEPORT;
		end else if (writes && (busy_dec[rd] > lat)) begin
			reason = RSN_WAW;
		end else if (instr_s1.rob_full) begin
			reason = RSN_ROB_FULL;
		end else begin
			reason = RSN_NONE;
		end
	end

	assign issue = (reason == RSN_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				busy_q[i] <= '0;
			end
			slot_q  <= '0;
			float_q <= '0;
		end else if (advance) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				if (issue && writes && (rd == REG_W'(i))) begin
					busy_q[i] <= lat;
				end else begin
					busy_q[i] <= busy_dec[i];
				end
			end
			slot_q  <= (issue && writes) ? (slot_dec | slot) : slot_dec;
			float_q <= (issue && is_float) ? BUSY_W'(FLOAT_STALL) : float_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res.issued       <= issue;
			res.stall_reason <= reason;
			res.done_after   <= issue ? (lat + {2'b00, writes}) : 3'd0;
		end
	end

endmodule
